// ----- sv/tsop_pkg.sv -----
// ----------------------------------------------------------------------------
// tsop_pkg
// Shared types and constants for the TCP SYN option parser.
// ----------------------------------------------------------------------------
package tsop_pkg;

  // option kinds
  localparam logic [7:0] KIND_END    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;

  // option lengths, counting kind and length bytes
  localparam logic [7:0] LEN_MIN     = 8'd2;
  localparam logic [7:0] LEN_WSCALE  = 8'd3;
  localparam logic [7:0] LEN_MSS     = 8'd4;

  // byte positions inside an option body
  localparam logic [7:0] IDX_BODY_FIRST  = 8'd2;
  localparam logic [7:0] IDX_BODY_SECOND = 8'd3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // parser phase
  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  // classified request, as held in the queue
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       last;
    logic       has;
    logic       is_end;     // byte equals end-of-list kind
    logic       is_nop;     // byte equals no-operation kind
    logic       is_mss;     // byte equals MSS kind
    logic       is_wscale;  // byte equals window-scale kind
    logic       len_short;  // byte below minimum length
    logic       len_min;    // byte equals minimum length
  } q_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- sv/tsop_front.sv -----
// ----------------------------------------------------------------------------
// tsop_front
// Accepts input requests, drops empty non-final ones and classifies the byte.
// ----------------------------------------------------------------------------
module tsop_front
  import tsop_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] opt_byte,
  input  logic       last_byte,
  input  logic       has_byte,
  input  q_status_t  q_status,
  output logic       push,
  output q_entry_t   push_entry
);

  // take a request whenever the queue has room
  assign in_ready = !q_status.full;

  // an empty request that is not final carries nothing
  assign push = in_valid && in_ready && (has_byte || last_byte);

  // byte classification, used by whichever phase the back is in
  always_comb begin
    push_entry.opt_byte  = opt_byte;
    push_entry.last      = last_byte;
    push_entry.has       = has_byte;
    push_entry.is_end    = (opt_byte == KIND_END);
    push_entry.is_nop    = (opt_byte == KIND_NOP);
    push_entry.is_mss    = (opt_byte == KIND_MSS);
    push_entry.is_wscale = (opt_byte == KIND_WSCALE);
    push_entry.len_short = (opt_byte < LEN_MIN);
    push_entry.len_min   = (opt_byte == LEN_MIN);
  end

endmodule

// ----- sv/tsop_queue.sv -----
// ----------------------------------------------------------------------------
// tsop_queue
// Short FIFO between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
module tsop_queue
  import tsop_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

// ----- sv/tsop_back.sv -----
// ----------------------------------------------------------------------------
// tsop_back
// Walks kind, length and body of each option and holds the result register.
// ----------------------------------------------------------------------------
module tsop_back
  import tsop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    head,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] mss_value,
  output logic        wscale_present,
  output logic [7:0]  wscale_value
);

  phase_t      phase,       phase_next;
  logic        kind_mss,    kind_mss_next;
  logic        kind_ws,     kind_ws_next;
  logic [7:0]  cur_len,     cur_len_next;
  logic [7:0]  idx,         idx_next;
  logic [7:0]  held_high,   held_high_next;
  logic [15:0] found_mss,   found_mss_next;
  logic        found_wsf,   found_wsf_next;
  logic [7:0]  found_ws,    found_ws_next;
  logic        done;

  // stall only when a final request meets a result still waiting
  assign pop = !q_status.empty && !(head.last && out_valid && !out_ready);

  assign done = ({1'b0, idx} + 9'd1) == {1'b0, cur_len};

  // parse step
  always_comb begin
    phase_next     = phase;
    kind_mss_next  = kind_mss;
    kind_ws_next   = kind_ws;
    cur_len_next   = cur_len;
    idx_next       = idx;
    held_high_next = held_high;
    found_mss_next = found_mss;
    found_wsf_next = found_wsf;
    found_ws_next  = found_ws;
    if (pop && head.has) begin
      unique case (phase)
        PH_KIND: begin
          if (head.is_end) begin
            phase_next = PH_STOP;
          end else if (!head.is_nop) begin
            kind_mss_next = head.is_mss;
            kind_ws_next  = head.is_wscale;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (head.len_short) begin
            phase_next = PH_STOP;
          end else begin
            cur_len_next = head.opt_byte;
            idx_next     = LEN_MIN;
            // no body: option complete already
            phase_next   = head.len_min ? PH_KIND : PH_BODY;
          end
        end
        PH_BODY: begin
          if (kind_mss && cur_len == LEN_MSS) begin
            if (idx == IDX_BODY_FIRST) begin
              held_high_next = head.opt_byte;
            end else if (idx == IDX_BODY_SECOND && done) begin
              found_mss_next = {held_high, head.opt_byte};
            end
          end else if (kind_ws && cur_len == LEN_WSCALE) begin
            if (idx == IDX_BODY_FIRST && done) begin
              found_wsf_next = 1'b1;
              found_ws_next  = head.opt_byte;
            end
          end
          if (done) begin
            phase_next = PH_KIND;
            idx_next   = '0;
          end else begin
            idx_next = idx + 8'd1;
          end
        end
        PH_STOP: begin
          phase_next = PH_STOP;
        end
        default: begin
          phase_next = PH_STOP;
        end
      endcase
    end
  end

  // parser state, cleared after every final request
  always_ff @(posedge clk) begin
    if (rst || (pop && head.last)) begin
      phase     <= PH_KIND;
      kind_mss  <= 1'b0;
      kind_ws   <= 1'b0;
      cur_len   <= '0;
      idx       <= '0;
      held_high <= '0;
      found_mss <= '0;
      found_wsf <= 1'b0;
      found_ws  <= '0;
    end else begin
      phase     <= phase_next;
      kind_mss  <= kind_mss_next;
      kind_ws   <= kind_ws_next;
      cur_len   <= cur_len_next;
      idx       <= idx_next;
      held_high <= held_high_next;
      found_mss <= found_mss_next;
      found_wsf <= found_wsf_next;
      found_ws  <= found_ws_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      mss_value      <= found_mss_next;
      wscale_present <= found_wsf_next;
      wscale_value   <= found_ws_next;
    end
  end

endmodule

// ----- sv/tcp_syn_option_parser.sv -----
// ----------------------------------------------------------------------------
// tcp_syn_option_parser
// Parses a TCP option area byte by byte and reports MSS and window scale.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_ready | opt_byte, last_byte, has_byte
//  output  | out_valid/out_ready | mss_value, wscale_present, wscale_value
//
//  One byte is taken per cycle while the queue has room.
//  A result is offered once its final byte has passed the queue write and then
//  the result register, and may wait there while further bytes are taken.
//  Synchronous reset empties the queue, clears the parser and drops any result.
//  A final byte stalls in the queue only while the previous result waits.
// ----------------------------------------------------------------------------
module tcp_syn_option_parser
  import tsop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opt_byte,
  input  logic        last_byte,
  input  logic        has_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] mss_value,
  output logic        wscale_present,
  output logic [7:0]  wscale_value
);

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  tsop_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opt_byte   (opt_byte),
    .last_byte  (last_byte),
    .has_byte   (has_byte),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  tsop_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  tsop_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mss_value      (mss_value),
    .wscale_present (wscale_present),
    .wscale_value   (wscale_value)
  );

endmodule

// ----- sv/tsop_checker.sv -----
// ----------------------------------------------------------------------------
// tsop_checker
// Port-level checks for the TCP SYN option parser, bound to the top level.
// ----------------------------------------------------------------------------
module tsop_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] mss_value,
  input logic        wscale_present,
  input logic [7:0]  wscale_value
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mss_value)
      && $stable(wscale_present) && $stable(wscale_value))
    else $error("result changed while stalled");

  // shift count is zero without a window-scale option
  a_ws_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !wscale_present |-> wscale_value == 8'd0)
    else $error("window scale set without flag");

  // reset drops any pending result
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // reset leaves the queue empty and ready
  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("not ready after reset");

endmodule

bind tcp_syn_option_parser tsop_checker u_tsop_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .mss_value      (mss_value),
  .wscale_present (wscale_present),
  .wscale_value   (wscale_value)
);

// ----- test/tb_tcp_syn_option_parser.sv -----
// ----------------------------------------------------------------------------
// tb_tcp_syn_option_parser
// Self-checking bench for the TCP SYN option parser. A short table of option
// areas covers each option kind, the field extremes and the broken forms:
// parsing stopped, length below two, cut-off options, wrong lengths and empty
// requests. Random option areas follow, mostly well formed. The sender works
// in bursts and the receiver stalls, with one long hold-off. Each result is
// compared with a typed table row or a local MSS and window-scale model.
// ----------------------------------------------------------------------------
module tb_tcp_syn_option_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import tsop_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int DIR_ROWS     = 27;

  // one header's worth of findings
  typedef struct packed {
    logic [15:0] mss;
    logic        ws_present;
    logic [7:0]  ws;
  } syn_opts_t;

  // directed row: request fields, then a typed result where chk is set
  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic        h;
    logic        chk;
    logic [15:0] mss;
    logic        wsp;
    logic [7:0]  ws;
  } dir_row_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  opt_byte       = 8'h00;
  logic        last_byte      = 1'b0;
  logic        has_byte       = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [15:0] mss_value;
  logic        wscale_present;
  logic [7:0]  wscale_value;

  // local parser state
  phase_t      parse_ph;
  logic [7:0]  opt_kind;
  logic [7:0]  opt_len;
  logic [7:0]  opt_idx;
  logic [7:0]  mss_high;
  logic [15:0] found_mss;
  logic        found_ws_flag;
  logic [7:0]  found_ws;

  syn_opts_t   expected_opts_q[$];
  int          errors      = 0;
  int          sent_items  = 0;
  int          burst_left  = 0;
  bit          hold_go     = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // empty area straight after reset
    '{8'h00, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0, 8'h00},
    // largest MSS
    '{KIND_MSS, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{LEN_MSS,  1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hFF,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hFF,    1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b0, 8'h00},
    // no-op then largest window scale
    '{KIND_NOP,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{KIND_WSCALE, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{LEN_WSCALE,  1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hFF,       1'b1, 1'b1, 1'b1, 16'h0000, 1'b1, 8'hFF},
    // length below two stops parsing, later byte ignored
    '{8'h05, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'h01, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hAB, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00},
    // MSS cut off before its low byte
    '{KIND_MSS, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{LEN_MSS,  1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'h12,    1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00},
    // kind byte with no length byte
    '{KIND_WSCALE, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    // MSS of wrong length, an ignored empty request inside, then end of list
    '{KIND_MSS, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'h05,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hAA,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'h5A,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hBB,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hCC,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{KIND_END, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    // zero shift, closed by an empty last request
    '{KIND_WSCALE, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{LEN_WSCALE,  1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'h00,       1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 8'h00},
    '{8'hC3,       1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, 8'h00}
  };

  tcp_syn_option_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opt_byte       (opt_byte),
    .last_byte      (last_byte),
    .has_byte       (has_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mss_value      (mss_value),
    .wscale_present (wscale_present),
    .wscale_value   (wscale_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // back to the state of a fresh header
  function automatic void clear_parser();
    parse_ph      = PH_KIND;
    opt_kind      = '0;
    opt_len       = '0;
    opt_idx       = '0;
    mss_high      = '0;
    found_mss     = '0;
    found_ws_flag = 1'b0;
    found_ws      = '0;
  endfunction

  // walk one option byte through kind, length and body
  function automatic void parse_option_byte(input logic [7:0] b);
    logic done;
    done = ({1'b0, opt_idx} + 9'd1) == {1'b0, opt_len};
    case (parse_ph)
      PH_KIND: begin
        if (b == KIND_END) begin
          parse_ph = PH_STOP;
        end else if (b != KIND_NOP) begin
          opt_kind = b;
          parse_ph = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < LEN_MIN) begin
          parse_ph = PH_STOP;
        end else begin
          opt_len  = b;
          opt_idx  = LEN_MIN;
          parse_ph = (b == LEN_MIN) ? PH_KIND : PH_BODY;
        end
      end
      PH_BODY: begin
        if (opt_kind == KIND_MSS && opt_len == LEN_MSS) begin
          if (opt_idx == IDX_BODY_FIRST) begin
            mss_high = b;
          end else if (opt_idx == IDX_BODY_SECOND && done) begin
            found_mss = {mss_high, b};
          end
        end else if (opt_kind == KIND_WSCALE && opt_len == LEN_WSCALE) begin
          if (opt_idx == IDX_BODY_FIRST && done) begin
            found_ws_flag = 1'b1;
            found_ws      = b;
          end
        end
        if (done) begin
          parse_ph = PH_KIND;
          opt_idx  = '0;
        end else begin
          opt_idx = opt_idx + 8'd1;
        end
      end
      default: ;
    endcase
  endfunction

  // offer one request, wait for it to be taken, then fold it into the model
  task automatic send_request(input logic [7:0] b, input logic l, input logic h,
                              input logic chk, input syn_opts_t typed);
    bit taken;
    syn_opts_t got;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    in_valid  <= 1'b1;
    opt_byte  <= b;
    last_byte <= l;
    has_byte  <= h;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (h || l) sent_items++;
    if (h) parse_option_byte(b);
    if (l) begin
      got = '{mss: found_mss, ws_present: found_ws_flag, ws: found_ws};
      expected_opts_q.push_back(chk ? typed : got);
      clear_parser();
    end
  endtask

  // one random option area, mostly well-formed options
  task automatic send_random_header();
    logic [7:0] bytes_q[$];
    logic [7:0] kind;
    logic [7:0] len;
    int n_opts;
    int pick;
    int cut;
    bit empty_tail;
    n_opts = $urandom_range(0, 5);
    for (int i = 0; i < n_opts; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        bytes_q.push_back(KIND_NOP);
      end else if (pick < 14) begin
        bytes_q.push_back(KIND_END);
      end else if (pick < 40) begin
        bytes_q.push_back(KIND_MSS);
        bytes_q.push_back(LEN_MSS);
        bytes_q.push_back($urandom_range(0, 255));
        bytes_q.push_back($urandom_range(0, 255));
      end else if (pick < 60) begin
        bytes_q.push_back(KIND_WSCALE);
        bytes_q.push_back(LEN_WSCALE);
        bytes_q.push_back($urandom_range(0, 255));
      end else if (pick < 78) begin
        // unknown kind, or MSS / window scale at the wrong length
        if (pick < 70) begin
          kind = $urandom_range(4, 255);
          len  = $urandom_range(2, 8);
        end else begin
          kind = pick[0] ? KIND_MSS : KIND_WSCALE;
          do len = $urandom_range(2, 7);
          while (len == ((kind == KIND_MSS) ? LEN_MSS : LEN_WSCALE));
        end
        bytes_q.push_back(kind);
        bytes_q.push_back(len);
        for (int j = 2; j < len; j++) bytes_q.push_back($urandom_range(0, 255));
      end else if (pick < 82) begin
        bytes_q.push_back($urandom_range(2, 255));
        bytes_q.push_back($urandom_range(0, 1));
      end else begin
        bytes_q.push_back($urandom_range(0, 255));
      end
    end
    // sometimes cut the area short, possibly mid-option
    if (bytes_q.size() > 1 && $urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, bytes_q.size() - 1);
      while (bytes_q.size() > cut) void'(bytes_q.pop_back());
    end
    empty_tail = (bytes_q.size() == 0) || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < bytes_q.size(); i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request($urandom_range(0, 255), 1'b0, 1'b0, 1'b0, '0);
      send_request(bytes_q[i], !empty_tail && (i == bytes_q.size() - 1), 1'b1,
                   1'b0, '0);
    end
    if (empty_tail) send_request($urandom_range(0, 255), 1'b1, 1'b0, 1'b0, '0);
  endtask

  // receiver: one long hold-off, otherwise a changing stall pattern
  initial begin : rx_side
    logic [7:0] pattern;
    int mode;
    int left;
    int ph;
    mode = 0;
    left = 0;
    ph   = 0;
    pattern = 8'hFF;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode    = $urandom_range(0, 2);
          left    = $urandom_range(20, 120);
          pattern = $urandom_range(1, 255);
        end
        left = left - 1;
        ph   = (ph + 1) % 8;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= pattern[ph];
          default: out_ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // result check, sampled mid-cycle
  always @(negedge clk) begin : result_check
    syn_opts_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_opts_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: mss %h wsp %b ws %h", $time,
                 mss_value, wscale_present, wscale_value);
      end else begin
        want = expected_opts_q.pop_front();
        if (mss_value !== want.mss) begin
          errors++;
          $display("%0t mss_value: expected %h actual %h", $time, want.mss, mss_value);
        end
        if (wscale_present !== want.ws_present) begin
          errors++;
          $display("%0t wscale_present: expected %b actual %b", $time,
                   want.ws_present, wscale_present);
        end
        if (wscale_value !== want.ws) begin
          errors++;
          $display("%0t wscale_value: expected %h actual %h", $time,
                   want.ws, wscale_value);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(negedge clk) begin : watchdog
    int idle;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle = 0;
    end else begin
      idle = idle + 1;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t timeout: no request or result moved for %0d cycles", $time, idle);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    syn_opts_t typed;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      typed = '{mss: dir_tab[r].mss, ws_present: dir_tab[r].wsp, ws: dir_tab[r].ws};
      send_request(dir_tab[r].b, dir_tab[r].l, dir_tab[r].h, dir_tab[r].chk, typed);
    end

    // random option areas, with the long receiver hold-off near the start
    sent_items = 0;
    hold_go = 1'b1;
    while (sent_items < RANDOM_ITEMS) send_random_header();

    in_valid <= 1'b0;
    while (expected_opts_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
